>>> src/vdzf_pkg.sv
// ----------------------------------------------------------------------------
// vdzf_pkg: shared types and constants for the viewport dead-zone follow core
// Holds register codes, follow modes, config and camera state structs, and
// the corner limit shared by the update logic and the top level.
// ----------------------------------------------------------------------------
package vdzf_pkg;

  localparam int POS_W              = 15;  // map positions and corners
  localparam int VIEW_W             = 14;  // viewport size
  localparam int MODE_W             = 2;
  localparam int CALC_W             = 18;  // signed working width of the update math
  localparam int ZONE_X             = 128; // dead-zone margin, horizontal
  localparam int ZONE_Y             = 64;  // dead-zone margin, vertical
  localparam int DEFAULT_COORD_BITS = 16;
  localparam int REG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 15;
  localparam int TDATA_W            = 32;

  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [VIEW_W-1:0]        view_t;
  typedef logic [MODE_W-1:0]        mode_t;
  typedef logic [REG_IDX_W-1:0]     reg_idx_t;
  typedef logic signed [CALC_W-1:0] calc_t;

  // Follow modes
  localparam mode_t MODE_CENTER    = 2'd0;
  localparam mode_t MODE_ZONE      = 2'd1;
  localparam mode_t MODE_DIRECTION = 2'd2;

  // Register indexes
  localparam reg_idx_t REG_FOLLOW_MODE = 3'd0;
  localparam reg_idx_t REG_MAP_WIDTH   = 3'd1;
  localparam reg_idx_t REG_MAP_HEIGHT  = 3'd2;
  localparam reg_idx_t REG_VIEW_WIDTH  = 3'd3;
  localparam reg_idx_t REG_VIEW_HEIGHT = 3'd4;

  // Reset values of the registers
  localparam mode_t RST_FOLLOW_MODE = MODE_CENTER;
  localparam pos_t  RST_MAP_WIDTH   = 15'd32767;
  localparam pos_t  RST_MAP_HEIGHT  = 15'd32767;
  localparam view_t RST_VIEW_WIDTH  = 14'd1024;
  localparam view_t RST_VIEW_HEIGHT = 14'd768;

  typedef struct packed {
    mode_t follow_mode;
    pos_t  map_width;
    pos_t  map_height;
    view_t view_width;
    view_t view_height;
  } cfg_t;

  typedef struct packed {
    pos_t corner_left;
    pos_t corner_top;
    pos_t last_x;
    pos_t last_y;
    logic last_valid;
  } cam_state_t;

  // Largest corner value: min(32767, 2^coord_bits - 1). Also serves as the
  // mask applied to a stored last target.
  function automatic pos_t corner_max(input int coord_bits);
    pos_t m;
    if (coord_bits >= POS_W) begin
      m = '1;
    end else begin
      m = pos_t'((1 << coord_bits) - 1);
    end
    return m;
  endfunction

endpackage

>>> src/viewport_dead_zone_follow_core.sv
// ----------------------------------------------------------------------------
// viewport_dead_zone_follow_core: camera follow with center, dead-zone and
// direction-keeping modes
// Takes target positions and returns the updated viewport corner per target.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  --------  ---------  --------------------------  ---------------------------
//  s_axis    in         s_axis_tvalid/tready        tdata: target_x, target_y
//  m_axis    out        m_axis_tvalid/tready        tdata: view_left, view_top;
//                                                   tuser: moved
//  cfg       in         cfg_valid/cfg_ready         cfg_index, cfg_data
//
//  One target per cycle sustained while m_axis is ready. A target is held in the
//  input register, the single update path then writes the result register and
//  the camera state together, so each result is registered and then held until
//  it is taken. Back-to-back targets see the state left by the one before them.
//  Reset (rst, synchronous) clears the corner, the last target and its valid
//  flag, and loads the register defaults. A stalled m_axis holds the result
//  and the input register; s_axis stalls only when both are full.
//  cfg_ready is always high; write registers only while the core is idle.
//
module viewport_dead_zone_follow_core
  import vdzf_pkg::*;
#(
  parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // [14:0] target_x, [29:15] target_y, zero pad

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // [14:0] view_left, [29:15] view_top, zero pad
  output logic                  m_axis_tuser,   // [0] moved

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  reg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam pos_t CMAX = corner_max(COORD_BITS);

  // Configuration registers
  cfg_t cfg;

  // Input register
  logic in_valid;
  pos_t in_x;
  pos_t in_y;

  // Result register
  logic out_valid;
  pos_t out_left;
  pos_t out_top;
  logic out_moved;

  // Camera state
  cam_state_t state;
  cam_state_t state_next;
  pos_t       step_left;
  pos_t       step_top;
  logic       step_moved;
  logic       advance;

  // Move the held target into the result register when that register frees up
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration writes; unknown indexes are dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.follow_mode <= RST_FOLLOW_MODE;
      cfg.map_width   <= RST_MAP_WIDTH;
      cfg.map_height  <= RST_MAP_HEIGHT;
      cfg.view_width  <= RST_VIEW_WIDTH;
      cfg.view_height <= RST_VIEW_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FOLLOW_MODE: cfg.follow_mode <= cfg_data[MODE_W-1:0];
        REG_MAP_WIDTH:   cfg.map_width   <= cfg_data[POS_W-1:0];
        REG_MAP_HEIGHT:  cfg.map_height  <= cfg_data[POS_W-1:0];
        REG_VIEW_WIDTH:  cfg.view_width  <= cfg_data[VIEW_W-1:0];
        REG_VIEW_HEIGHT: cfg.view_height <= cfg_data[VIEW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register: hold a target until the update path can take it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_x <= s_axis_tdata[POS_W-1:0];
      in_y <= s_axis_tdata[2*POS_W-1:POS_W];
    end
  end

  // --------------------------------------------------------------------------
  // Update path
  // --------------------------------------------------------------------------
  vdzf_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .cfg       (cfg),
    .target_x  (in_x),
    .target_y  (in_y),
    .st        (state),
    .st_next   (state_next),
    .view_left (step_left),
    .view_top  (step_top),
    .moved     (step_moved)
  );

  // Camera state advances together with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_left  <= step_left;
      out_top   <= step_top;
      out_moved <= step_moved;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(TDATA_W - 2*POS_W){1'b0}}, out_top, out_left};
  assign m_axis_tuser  = out_moved;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The result register always shows the corner the state just took on
  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_left == state.corner_left) && (out_top == state.corner_top))
    else $error("result corner differs from stored corner");

  // moved is set exactly when the stored corner changed
  a_moved_flag: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_moved == ((state.corner_left != $past(state.corner_left)) ||
                               (state.corner_top != $past(state.corner_top)))))
    else $error("moved flag disagrees with corner change");

  // The corner only changes when a target passes through the update path
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("camera state changed without an update");

  // The corner never leaves its legal range
  a_corner_range: assert property (@(posedge clk) disable iff (rst)
    (state.corner_left <= CMAX) && (state.corner_top <= CMAX))
    else $error("corner out of range");

endmodule

>>> src/vdzf_step.sv
// ----------------------------------------------------------------------------
// vdzf_step: one camera update
// Computes the new viewport corner, the moved flag and the next camera state
// from one target position, the current state and the configuration.
// ----------------------------------------------------------------------------
module vdzf_step
  import vdzf_pkg::*;
#(
  parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
  input  cfg_t       cfg,
  input  pos_t       target_x,
  input  pos_t       target_y,
  input  cam_state_t st,
  output cam_state_t st_next,
  output pos_t       view_left,
  output pos_t       view_top,
  output logic       moved
);

  localparam pos_t  CMAX   = corner_max(COORD_BITS);
  localparam calc_t CMAX_C = calc_t'(CMAX);

  function automatic pos_t limit(input calc_t v);
    pos_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > CMAX_C) begin
      r = CMAX;
    end else begin
      r = pos_t'(v);
    end
    return r;
  endfunction

  function automatic pos_t clamp_edge(input calc_t v, input calc_t map, input calc_t view);
    calc_t n;
    n = v;
    if (v < 0) begin
      n = '0;
    end else if (v > map - view) begin
      n = map - view;
    end
    return limit(n);
  endfunction

  // Center on the target; a zero map size leaves that axis unbounded
  function automatic pos_t centre_axis(input calc_t t, input calc_t map, input calc_t view);
    calc_t half;
    calc_t c;
    half = view >>> 1;
    c    = t;
    if (map != 0) begin
      if (c + half > map) begin
        c = map - half;
      end
      if (c < half) begin
        c = half;
      end
    end
    return limit(c - half);
  endfunction

  // Move only when the target leaves the zone; a view below the margin gives a
  // negative inset, halved toward zero
  function automatic pos_t zone_axis(input calc_t t, input calc_t corner, input calc_t view,
                                     input calc_t margin, input calc_t map);
    calc_t d;
    calc_t ins;
    calc_t n;
    d   = view - margin;
    ins = (d + ((d < 0) ? calc_t'(1) : calc_t'(0))) >>> 1;
    n   = corner;
    if (t < corner + ins) begin
      n = t - ins;
    end else if (t > corner + view - ins) begin
      n = t + ins - view;
    end
    return clamp_edge(n, map, view);
  endfunction

  function automatic logic near_edge(input calc_t p, input calc_t half, input calc_t map);
    return (p < half) || (p > map - half);
  endfunction

  calc_t tx, ty, mw, mh, vw, vh, cl, ct;
  calc_t hw, hh, lx, ly, ix, iy;
  pos_t  mask_x, mask_y;
  pos_t  zone_l, zone_t, centre_l, centre_t, shift_l, shift_t;
  logic  near_hit, outside;
  pos_t  nl, nt;

  assign tx = calc_t'(target_x);
  assign ty = calc_t'(target_y);
  assign mw = calc_t'(cfg.map_width);
  assign mh = calc_t'(cfg.map_height);
  assign vw = calc_t'(cfg.view_width);
  assign vh = calc_t'(cfg.view_height);
  assign cl = calc_t'(st.corner_left);
  assign ct = calc_t'(st.corner_top);
  assign hw = vw >>> 1;
  assign hh = vh >>> 1;

  assign mask_x = target_x & CMAX;
  assign mask_y = target_y & CMAX;

  // On the first target the last target is taken equal to the current one
  assign lx = st.last_valid ? calc_t'(st.last_x) : calc_t'(mask_x);
  assign ly = st.last_valid ? calc_t'(st.last_y) : calc_t'(mask_y);

  assign centre_l = centre_axis(tx, mw, vw);
  assign centre_t = centre_axis(ty, mh, vh);
  assign zone_l   = zone_axis(tx, cl, vw, calc_t'(ZONE_X), mw);
  assign zone_t   = zone_axis(ty, ct, vh, calc_t'(ZONE_Y), mh);
  assign shift_l  = clamp_edge(cl + tx - lx, mw, vw);
  assign shift_t  = clamp_edge(ct + ty - ly, mh, vh);

  assign near_hit = near_edge(tx, hw, mw) || near_edge(ty, hh, mh) ||
                    near_edge(lx, hw, mw) || near_edge(ly, hh, mh);

  assign ix = hw - calc_t'(ZONE_X / 2);
  assign iy = hh - calc_t'(ZONE_Y / 2);
  assign outside = (tx < cl + ix) || (tx > cl + vw - ix) ||
                   (ty < ct + iy) || (ty > ct + vh - iy);

  always_comb begin
    nl      = st.corner_left;
    nt      = st.corner_top;
    st_next = st;
    case (cfg.follow_mode)
      MODE_CENTER: begin
        nl = centre_l;
        nt = centre_t;
      end
      MODE_ZONE: begin
        nl = zone_l;
        nt = zone_t;
      end
      MODE_DIRECTION: begin
        if (near_hit) begin
          nl = zone_l;
          nt = zone_t;
        end else if (outside) begin
          nl = shift_l;
          nt = shift_t;
        end
        st_next.last_x     = mask_x;
        st_next.last_y     = mask_y;
        st_next.last_valid = 1'b1;
      end
      default: begin
        // unused mode: hold everything
      end
    endcase
    st_next.corner_left = nl;
    st_next.corner_top  = nt;
  end

  assign view_left = nl;
  assign view_top  = nt;
  assign moved     = (nl != st.corner_left) || (nt != st.corner_top);

endmodule

>>> dv/vdzf_tb_pkg.sv
// ----------------------------------------------------------------------------
// vdzf_tb_pkg: camera scoreboard for the viewport dead-zone follow core
// Tracks the register settings and the camera state, predicts the corner for
// every accepted target and checks the returned views in order.
// ----------------------------------------------------------------------------
package vdzf_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import vdzf_pkg::*;

  localparam mode_t    MODE_UNUSED = 2'd3;
  localparam reg_idx_t REG_SPARE   = 3'd7;
  localparam longint   POS_MAX     = (longint'(1) << POS_W) - 1;
  localparam int       MAX_REPORTS = 20;

  typedef struct packed {
    pos_t left;
    pos_t top;
    logic moved;
  } view_update_t;

  class camera_scoreboard;
    int           coord_bits;
    mode_t        mode;
    pos_t         map_w;
    pos_t         map_h;
    view_t        view_w;
    view_t        view_h;
    longint       corner_left;
    longint       corner_top;
    longint       last_x;
    longint       last_y;
    bit           last_valid;
    view_update_t pending_views[$];
    int           errors;
    int           checked;
    int           noted;

    function new(int coord_bits_in);
      coord_bits  = coord_bits_in;
      mode        = RST_FOLLOW_MODE;
      map_w       = RST_MAP_WIDTH;
      map_h       = RST_MAP_HEIGHT;
      view_w      = RST_VIEW_WIDTH;
      view_h      = RST_VIEW_HEIGHT;
      corner_left = 0;
      corner_top  = 0;
      last_x      = 0;
      last_y      = 0;
      last_valid  = 0;
      errors      = 0;
      checked     = 0;
      noted       = 0;
    endfunction

    // Mirror a register write; drop bits above each register's width.
    function void load_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FOLLOW_MODE: mode   = data[MODE_W-1:0];
        REG_MAP_WIDTH:   map_w  = data[POS_W-1:0];
        REG_MAP_HEIGHT:  map_h  = data[POS_W-1:0];
        REG_VIEW_WIDTH:  view_w = data[VIEW_W-1:0];
        REG_VIEW_HEIGHT: view_h = data[VIEW_W-1:0];
        default: ;
      endcase
    endfunction

    function longint corner_limit(longint v);
      longint m;
      m = (longint'(1) << coord_bits) - 1;
      if (m > POS_MAX) m = POS_MAX;
      if (v < 0) v = 0;
      if (v > m) v = m;
      return v;
    endfunction

    // Keep the view on the map; a map smaller than the view pins it at zero.
    function longint clamp_to_map(longint v, longint map, longint view);
      if (v < 0) v = 0;
      else if (v > map - view) v = map - view;
      return corner_limit(v);
    endfunction

    // A zero map size leaves that axis unbounded by the map.
    function longint center_axis(longint t, longint map, longint view);
      longint half;
      half = view / 2;
      if (map != 0) begin
        if (t + half > map) t = map - half;
        if (t < half) t = half;
      end
      return corner_limit(t - half);
    endfunction

    // Inset may go negative for a view narrower than the margin.
    function longint zone_axis(longint t, longint corner, longint view, longint margin,
                               longint map);
      longint ins;
      longint n;
      ins = (view - margin) / 2;
      n   = corner;
      if (t < corner + ins) n = t - ins;
      else if (t > corner + view - ins) n = t + ins - view;
      return clamp_to_map(n, map, view);
    endfunction

    function bit near_edge(longint p, longint half, longint map);
      return (p < half) || (p > map - half);
    endfunction

    function view_update_t follow_step(pos_t tx_in, pos_t ty_in);
      longint       tx, ty, mw, mh, vw, vh, nl, nt, hw, hh, ix, iy, cmask;
      view_update_t res;
      tx    = tx_in;
      ty    = ty_in;
      mw    = map_w;
      mh    = map_h;
      vw    = view_w;
      vh    = view_h;
      nl    = corner_left;
      nt    = corner_top;
      cmask = (longint'(1) << coord_bits) - 1;
      case (mode)
        MODE_CENTER: begin
          nl = center_axis(tx, mw, vw);
          nt = center_axis(ty, mh, vh);
        end
        MODE_ZONE: begin
          nl = zone_axis(tx, corner_left, vw, ZONE_X, mw);
          nt = zone_axis(ty, corner_top, vh, ZONE_Y, mh);
        end
        MODE_DIRECTION: begin
          hw = vw / 2;
          hh = vh / 2;
          // first target seen: treat it as its own previous position
          if (!last_valid) begin
            last_x     = tx & cmask;
            last_y     = ty & cmask;
            last_valid = 1;
          end
          if (near_edge(tx, hw, mw) || near_edge(ty, hh, mh) ||
              near_edge(last_x, hw, mw) || near_edge(last_y, hh, mh)) begin
            nl = zone_axis(tx, corner_left, vw, ZONE_X, mw);
            nt = zone_axis(ty, corner_top, vh, ZONE_Y, mh);
          end else begin
            ix = hw - ZONE_X / 2;
            iy = hh - ZONE_Y / 2;
            if (tx < corner_left + ix || tx > corner_left + vw - ix ||
                ty < corner_top + iy || ty > corner_top + vh - iy) begin
              nl = clamp_to_map(corner_left + tx - last_x, mw, vw);
              nt = clamp_to_map(corner_top + ty - last_y, mh, vh);
            end
          end
          last_x = tx & cmask;
          last_y = ty & cmask;
        end
        default: ;  // unused mode: hold corner and last target
      endcase
      res.moved   = (nl != corner_left) || (nt != corner_top);
      corner_left = nl;
      corner_top  = nt;
      res.left    = pos_t'(nl);
      res.top     = pos_t'(nt);
      return res;
    endfunction

    function void note_target(pos_t x, pos_t y);
      pending_views.push_back(follow_step(x, y));
      noted++;
    endfunction

    function void report_field(string name, longint want, longint got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    endfunction

    function void check_view(pos_t left, pos_t top, logic moved);
      view_update_t want;
      if (pending_views.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected view: expected none, actual left %0d top %0d moved %0d",
                   $time, left, top, moved);
        return;
      end
      want = pending_views.pop_front();
      checked++;
      if (left !== want.left) report_field("view_left", want.left, left);
      if (top !== want.top) report_field("view_top", want.top, top);
      if (moved !== want.moved) report_field("moved", want.moved, moved);
    endfunction
  endclass

endpackage

>>> dv/tb_viewport_dead_zone_follow_core.sv
// ----------------------------------------------------------------------------
// tb_viewport_dead_zone_follow_core: self-checking bench for the follow core
// Drives target positions through the input stream under several register
// settings, with random idle bursts on both streams, and checks every view
// update against a transaction-level prediction of the camera.
// ----------------------------------------------------------------------------
module tb_viewport_dead_zone_follow_core;
  timeunit 1ns;
  timeprecision 1ps;

  import vdzf_pkg::*;
  import vdzf_tb_pkg::*;

  localparam int     RANDOM_ITEMS = 800;
  localparam int     CALM_ITEMS   = 120;    // last stretch runs with no idling
  localparam longint CYCLE_LIMIT  = 400000; // far above the slowest legal run

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;   // [14:0] target_x, [29:15] target_y
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;         // [14:0] view_left, [29:15] view_top
  logic                  m_axis_tuser;         // [0] moved
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  reg_idx_t              cfg_index     = REG_FOLLOW_MODE;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  camera_scoreboard sb;
  bit               calm     = 1'b0;
  int               settings = 0;
  longint           cycles   = 0;
  int               mode_items[4];

  viewport_dead_zone_follow_core #(
    .COORD_BITS(DEFAULT_COORD_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d views still pending", cycles,
               sb.pending_views.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Check every result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_view(m_axis_tdata[POS_W-1:0], m_axis_tdata[2*POS_W-1:POS_W], m_axis_tuser);
  end

  // Result side: stall in random bursts, hold ready high once calm.
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Optionally idle first (gap > 0), then hold one target until accepted and
  // note it with the scoreboard at the accepting edge.
  task automatic send_target(input pos_t x, input pos_t y, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {{(TDATA_W-2*POS_W){1'b0}}, y, x};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_target(x, y);
    mode_items[sb.mode]++;
  endtask

  // Drop valid and wait until every predicted view has come back; each target
  // yields exactly one view, so the core is idle at that point.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_views.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.load_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] mode_word,
                               input logic [CFG_DATA_W-1:0] mw,
                               input logic [CFG_DATA_W-1:0] mh,
                               input logic [CFG_DATA_W-1:0] vw,
                               input logic [CFG_DATA_W-1:0] vh);
    wait_idle();
    write_reg(REG_FOLLOW_MODE, mode_word);
    write_reg(REG_MAP_WIDTH, mw);
    write_reg(REG_MAP_HEIGHT, mh);
    write_reg(REG_VIEW_WIDTH, vw);
    write_reg(REG_VIEW_HEIGHT, vh);
    settings++;
  endtask

  // Map size: mostly roomy maps so direction mode reaches its inner branch,
  // with the extremes and tiny maps mixed in.
  function automatic logic [CFG_DATA_W-1:0] pick_map();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return CFG_DATA_W'(POS_MAX);
      1:       return CFG_DATA_W'(1);
      2:       return CFG_DATA_W'($urandom_range(0, 2000));
      default: return CFG_DATA_W'($urandom_range(2000, 32767));
    endcase
  endfunction

  // View size: the margin, 8192, any 15-bit word (bits above the
  // register width are dropped), or a typical size.
  function automatic logic [CFG_DATA_W-1:0] pick_view(input int margin);
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return CFG_DATA_W'(8192);
      1:       return CFG_DATA_W'(margin);
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(margin, 4096));
    endcase
  endfunction

  task automatic random_setting();
    logic [CFG_DATA_W-1:0] mode_word;
    int                    r;
    mode_word = $urandom;  // junk above the mode field must be ignored
    r = $urandom_range(0, 9);
    if (r < 3) mode_word[MODE_W-1:0] = MODE_CENTER;
    else if (r < 6) mode_word[MODE_W-1:0] = MODE_ZONE;
    else if (r < 9) mode_word[MODE_W-1:0] = MODE_DIRECTION;
    else mode_word[MODE_W-1:0] = MODE_UNUSED;
    apply_setting(mode_word, pick_map(), pick_map(), pick_view(ZONE_X), pick_view(ZONE_Y));
  endtask

  // Advance one axis of the target walk: small or large steps within the map,
  // now and then a jump anywhere in the field.
  function automatic longint walk(input longint p, input longint map);
    longint span;
    longint step;
    longint top;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 32767);
    span = ($urandom_range(0, 3) == 0) ? 400 : 40;
    step = $urandom_range(0, 2 * span);
    step -= span;
    top  = (map == 0) ? POS_MAX : ((map - 1 > POS_MAX) ? POS_MAX : map - 1);
    p += step;
    if (p < 0) p = 0;
    if (p > top) p = top;
    return p;
  endfunction

  initial begin
    int     sent;
    int     len;
    bit     gappy;
    int     gap;
    longint tx;
    longint ty;

    sb = new(DEFAULT_COORD_BITS);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults after reset: centered view on the full map.
    send_target(0, 0, 0);
    send_target(15'h7FFF, 15'h7FFF, 0);
    send_target(600, 500, 2);

    // Zero-size map leaves both axes unbounded by the map; view of 8192.
    apply_setting(CFG_DATA_W'(MODE_CENTER), 0, 0, 8192, 8192);
    send_target(0, 0, 0);
    send_target(15'h7FFF, 15'h7FFF, 0);

    // Views equal to the margin: dead zone shrinks to nothing.
    apply_setting(CFG_DATA_W'(MODE_ZONE), 32767, 32767, ZONE_X, ZONE_Y);
    send_target(0, 0, 0);
    send_target(70, 40, 0);
    send_target(15'h7FFF, 15'h7FFF, 1);
    send_target(32700, 10, 0);

    // View narrower than the margin: negative zone inset.
    apply_setting(CFG_DATA_W'(MODE_ZONE), 32767, 32767, 100, 40);
    send_target(500, 500, 0);
    send_target(450, 530, 0);

    // Direction mode: first target, moves inside and past the zone, then a
    // target near the map edge that falls back to dead-zone behavior.
    apply_setting(CFG_DATA_W'(MODE_DIRECTION), 4000, 3000, 1024, 768);
    send_target(2000, 1500, 0);
    send_target(2010, 1505, 0);
    send_target(2400, 1700, 0);
    send_target(2450, 1720, 3);
    send_target(30, 30, 0);
    send_target(2000, 1500, 0);

    // Map smaller than the view pins the corner at zero.
    apply_setting(CFG_DATA_W'(MODE_DIRECTION), 100, 50, 8192, 8192);
    send_target(60, 20, 0);
    send_target(90, 40, 0);

    // Unused mode holds the view; a write to a spare index is ignored.
    apply_setting(CFG_DATA_W'(MODE_UNUSED), 32767, 32767, 1024, 768);
    write_reg(REG_SPARE, '1);
    send_target(1234, 4321, 0);

    // Random phases: fresh setting, then a target walk with random content.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_setting();
      len   = $urandom_range(20, 80);
      gappy = ($urandom_range(0, 2) != 0);
      tx    = $urandom_range(0, 32767);
      ty    = $urandom_range(0, 32767);
      for (int i = 0; i < len && sent < RANDOM_ITEMS; i++) begin
        calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
        gap  = (!calm && gappy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        tx   = walk(tx, sb.map_w);
        ty   = walk(ty, sb.map_h);
        send_target(pos_t'(tx), pos_t'(ty), gap);
        sent++;
      end
    end

    // Drain, then keep watching for stray results before the summary.
    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.pending_views.size() != 0)
      $display("%0t: %0d predicted views never arrived", $time, sb.pending_views.size());

    $display("Sent %0d targets under %0d register settings; %0d views checked, %0d errors.",
             sb.noted, settings, sb.checked, sb.errors);
    $display("Targets per mode: center %0d, dead zone %0d, direction %0d, unused %0d.",
             mode_items[MODE_CENTER], mode_items[MODE_ZONE], mode_items[MODE_DIRECTION],
             mode_items[MODE_UNUSED]);
    if (sb.errors == 0 && sb.pending_views.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
